// File: design/bsm_pkg.sv
package bsm_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned RadiusW = 31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_SQD,
    ST_RDSQ,
    ST_CMP,
    ST_SQRT,
    ST_KCALC,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } state_t;

endpackage

// File: design/bsm_in_if.sv
interface bsm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bsm_pkg::CoordW-1:0]      center_x;
  logic signed [bsm_pkg::CoordW-1:0]      center_y;
  logic signed [bsm_pkg::CoordW-1:0]      center_z;
  logic        [bsm_pkg::RadiusW-1:0]     radius_in;
  logic                                   first_of_set;

  modport source (output valid, center_x, center_y, center_z, radius_in, first_of_set,
                  input ready);
  modport sink (input valid, center_x, center_y, center_z, radius_in, first_of_set,
                output ready);
endinterface

// File: design/bsm_out_if.sv
interface bsm_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bsm_pkg::CoordW-1:0]      merged_x;
  logic signed [bsm_pkg::CoordW-1:0]      merged_y;
  logic signed [bsm_pkg::CoordW-1:0]      merged_z;
  logic        [bsm_pkg::RadiusW-1:0]     merged_radius;

  modport source (output valid, merged_x, merged_y, merged_z, merged_radius, input ready);
  modport sink (input valid, merged_x, merged_y, merged_z, merged_radius, output ready);
endinterface

// File: design/bounding_sphere_merge.sv
// Running bounding-sphere merge on Q16.16 spheres.
// in_ch carries one sphere per transfer (center, radius, first_of_set flag);
// out_ch carries the running enclosing sphere, exactly one result per input.
// An item marked first_of_set replaces the running sphere and goes from the
// idle state straight to the output state. A merge where one sphere contains
// the other ends its work at the compare state; a full merge goes on through
// the square root, scale and division states. The full merge time is set by
// the shared 17x17 multiply-accumulate unit (squares of the offset and of the
// radius difference, then offset times scale), the 34-step square root and
// three 33-step restoring divisions, all run one after another by the sequencer.
// in_ch.ready is high only while idle, so one item is in work at a time.
// The result sits in an output register; the next item may be taken while it
// waits, and a finished item waits in its last state while out_ch stalls.
// Reset (rst, synchronous) clears the running sphere to the origin with
// radius zero and drops any pending result.
module bounding_sphere_merge (
  input logic         clk,
  input logic         rst,
  bsm_in_if.sink      in_ch,
  bsm_out_if.source   out_ch
);
  import bsm_pkg::*;

  localparam logic [RadiusW-1:0] RadiusMax = {RadiusW{1'b1}};

  state_t state, state_next;

  logic signed [CoordW-1:0] c1 [3];
  logic signed [CoordW-1:0] c0 [3];
  logic [RadiusW-1:0] r1, r0, rd, new_r;
  logic [32:0] dm [3];
  logic        dneg [3];
  logic [67:0] acc, dist2, sq_op, sq_res, sq_one;
  logic [33:0] distance, kk;
  logic [33:0] dv_rem;
  logic [32:0] dv_lo;
  logic [1:0]  comp, j;
  logic [5:0]  cnt;
  logic        o_valid;
  logic signed [CoordW-1:0] o_c [3];
  logic [RadiusW-1:0] o_r;

  // Shared multiply-accumulate unit: one 17x17 partial product per cycle.
  logic [33:0] ma, mb;
  logic [16:0] pa, pb;
  logic [33:0] prod;
  logic [67:0] prod_sh, mac_sum;
  logic signed [32:0] df [3];
  logic [67:0] sq_t;
  logic [35:0] big;
  logic [34:0] bigr;
  logic [34:0] dv_t;
  logic        dv_ge;
  logic signed [33:0] nc;

  always_comb begin
    ma = {1'b0, dm[comp]};
    mb = {1'b0, dm[comp]};
    case (state)
      ST_RDSQ: begin
        ma = {3'b0, rd};
        mb = {3'b0, rd};
      end
      ST_MUL: mb = kk;
      default: ;
    endcase
    pa = j[1] ? ma[33:17] : ma[16:0];
    pb = j[0] ? mb[33:17] : mb[16:0];
    prod = 34'(pa * pb);
    case (j)
      2'd0: prod_sh = {34'b0, prod};
      2'd3: prod_sh = {prod, 34'b0};
      default: prod_sh = {17'b0, prod, 17'b0};
    endcase
    mac_sum = acc + prod_sh;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df[i] = {c1[i][CoordW-1], c1[i]} - {c0[i][CoordW-1], c0[i]};
    end
    sq_t  = sq_res + sq_one;
    big   = 36'(sq_res[33:0]) + 36'(r0) + 36'(r1);
    bigr  = big[35:1];
    dv_t  = {dv_rem, dv_lo[32]};
    dv_ge = dv_t >= {1'b0, distance};
    nc    = dneg[comp] ? {{2{c0[comp][CoordW-1]}}, c0[comp]} - {1'b0, dv_lo}
                       : {{2{c0[comp][CoordW-1]}}, c0[comp]} + {1'b0, dv_lo};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_ch.valid) state_next = in_ch.first_of_set ? ST_OUT : ST_DIFF;
      ST_DIFF:  state_next = ST_SQ;
      ST_SQ:    if (j == 2'd3 && comp == 2'd2) state_next = ST_SQD;
      ST_SQD:   state_next = ST_RDSQ;
      ST_RDSQ:  if (j == 2'd3) state_next = ST_CMP;
      ST_CMP:   state_next = (dist2 <= acc) ? ST_OUT : ST_SQRT;
      ST_SQRT:  if (cnt == 6'd0) state_next = ST_KCALC;
      ST_KCALC: state_next = ST_MUL;
      ST_MUL:   if (j == 2'd3) state_next = ST_DIV;
      ST_DIV:   if (cnt == 6'd0) state_next = ST_APPLY;
      ST_APPLY: state_next = (comp == 2'd2) ? ST_OUT : ST_MUL;
      ST_OUT:   if (!o_valid || out_ch.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign in_ch.ready          = (state == ST_IDLE);
  assign out_ch.valid         = o_valid;
  assign out_ch.merged_x      = o_c[0];
  assign out_ch.merged_y      = o_c[1];
  assign out_ch.merged_z      = o_c[2];
  assign out_ch.merged_radius = o_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      o_valid <= 1'b0;
      c0[0]   <= '0;
      c0[1]   <= '0;
      c0[2]   <= '0;
      r0      <= '0;
    end else begin
      state <= state_next;
      // In the output state a drained register is refilled below instead.
      if (o_valid && out_ch.ready && state != ST_OUT) o_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_ch.valid) begin
          c1[0] <= in_ch.center_x;
          c1[1] <= in_ch.center_y;
          c1[2] <= in_ch.center_z;
          r1    <= in_ch.radius_in;
          if (in_ch.first_of_set) begin
            c0[0] <= in_ch.center_x;
            c0[1] <= in_ch.center_y;
            c0[2] <= in_ch.center_z;
            r0    <= in_ch.radius_in;
          end
        end
        ST_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            dneg[i] <= df[i][32];
            dm[i]   <= df[i][32] ? 33'(-df[i]) : 33'(df[i]);
          end
          rd   <= (r1 >= r0) ? r1 - r0 : r0 - r1;
          acc  <= '0;
          comp <= 2'd0;
          j    <= 2'd0;
        end
        ST_SQ: begin
          acc <= mac_sum;
          j   <= j + 2'd1;
          if (j == 2'd3) comp <= comp + 2'd1;
        end
        ST_SQD: begin
          dist2 <= acc;
          acc   <= '0;
          j     <= 2'd0;
        end
        ST_RDSQ: begin
          acc <= mac_sum;
          j   <= j + 2'd1;
        end
        ST_CMP: begin
          if (dist2 <= acc) begin
            if (r1 >= r0) begin
              c0[0] <= c1[0];
              c0[1] <= c1[1];
              c0[2] <= c1[2];
              r0    <= r1;
            end
          end
          sq_op  <= dist2;
          sq_res <= '0;
          sq_one <= 68'd1 << 66;
          cnt    <= 6'd33;
        end
        ST_SQRT: begin
          if (sq_op >= sq_t) begin
            sq_op  <= sq_op - sq_t;
            sq_res <= (sq_res >> 1) + sq_one;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_one <= sq_one >> 2;
          cnt    <= cnt - 6'd1;
        end
        ST_KCALC: begin
          distance <= sq_res[33:0];
          kk       <= (bigr >= 35'(r0)) ? 34'(bigr - 35'(r0)) : '0;
          new_r    <= (bigr > 35'(RadiusMax)) ? RadiusMax : bigr[RadiusW-1:0];
          acc      <= '0;
          comp     <= 2'd0;
          j        <= 2'd0;
        end
        ST_MUL: begin
          acc <= mac_sum;
          j   <= j + 2'd1;
          if (j == 2'd3) begin
            dv_rem <= mac_sum[66:33];
            dv_lo  <= mac_sum[32:0];
            cnt    <= 6'd32;
          end
        end
        ST_DIV: begin
          dv_rem <= dv_ge ? 34'(dv_t - {1'b0, distance}) : dv_t[33:0];
          dv_lo  <= {dv_lo[31:0], dv_ge};
          cnt    <= cnt - 6'd1;
        end
        ST_APPLY: begin
          if (distance != '0) c0[comp] <= nc[CoordW-1:0];
          comp <= comp + 2'd1;
          acc  <= '0;
          j    <= 2'd0;
          if (comp == 2'd2) r0 <= new_r;
        end
        ST_OUT: if (!o_valid || out_ch.ready) begin
          o_c[0]  <= c0[0];
          o_c[1]  <= c0[1];
          o_c[2]  <= c0[2];
          o_r     <= r0;
          o_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // The partial remainder stays below the divisor throughout the division.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (dv_rem < distance))
    else $error("division remainder not below divisor");

  // The center step never exceeds the distance.
  a_scale: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (kk <= distance))
    else $error("scale above distance");

  // A first item of a set goes straight to the output stage.
  a_first: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.first_of_set) |=> (state == ST_OUT))
    else $error("first item not loaded directly");

  // A result is loaded only when the output register is free or draining.
  a_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && o_valid && !out_ch.ready) |=> (state == ST_OUT))
    else $error("result lost under stall");

endmodule

// File: test/bsm_tb_if.sv
// The block's own interfaces (bsm_in_if, bsm_out_if) carry both channels.
// This file adds a small bundle so that the stall knobs can be shared.
interface bsm_tb_knobs;
  timeunit 1ns;
  timeprecision 1ps;

  int unsigned in_gap_max;
  int unsigned out_stall_max;
endinterface

// File: test/bounding_sphere_merge_tb.sv
module bounding_sphere_merge_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsm_pkg::*;

  localparam int unsigned NumRandom = 1200;
  localparam int unsigned MaxRows   = NumRandom + 64;
  localparam logic [30:0] RadMax = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [CoordW-1:0]  x;
    logic signed [CoordW-1:0]  y;
    logic signed [CoordW-1:0]  z;
    logic        [RadiusW-1:0] r;
  } sphere_t;

  typedef struct {
    sphere_t s;
    logic    first;
    logic    known;
    sphere_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  bit   feeding_done = 1'b0;

  bsm_in_if  in_ch ();
  bsm_out_if out_ch ();
  bsm_tb_knobs knobs ();

  bounding_sphere_merge i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #2 clk = ~clk;

  sphere_t     running;
  sphere_t     exp_list [MaxRows];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  row_t        rows [MaxRows];
  int unsigned row_count = 0;

  function automatic logic [63:0] root_floor(input logic [67:0] v);
    logic [35:0]  res;
    logic [35:0]  y;
    logic [71:0]  sq;
    res = '0;
    for (int b = 35; b >= 0; b--) begin
      y  = res | (36'd1 << b);
      sq = y * y;
      if (sq <= {4'd0, v}) res = y;
    end
    return {28'd0, res};
  endfunction

  // Advances the running sphere by one input item, as the block does.
  function automatic sphere_t merge_sphere(input sphere_t s, input logic first);
    logic signed [33:0] d[3];
    logic        [33:0] md[3];
    logic        [67:0] dist2;
    logic        [31:0] rd;
    logic        [67:0] rd2;
    logic        [63:0] distance;
    logic        [63:0] big_r;
    logic        [63:0] k;
    logic        [127:0] off;
    logic signed [CoordW-1:0] c0[3];
    logic signed [CoordW-1:0] c1[3];
    logic signed [CoordW-1:0] nc[3];
    sphere_t n;
    c0[0] = running.x; c0[1] = running.y; c0[2] = running.z;
    c1[0] = s.x;       c1[1] = s.y;       c1[2] = s.z;
    if (first) return s;
    dist2 = '0;
    for (int i = 0; i < 3; i++) begin
      d[i]  = 34'(c1[i]) - 34'(c0[i]);
      md[i] = d[i] < 0 ? 34'(-d[i]) : 34'(d[i]);
      dist2 = dist2 + 68'(md[i]) * 68'(md[i]);
    end
    rd  = s.r >= running.r ? 32'(s.r) - 32'(running.r) : 32'(running.r) - 32'(s.r);
    rd2 = 68'(rd) * 68'(rd);
    if (dist2 <= rd2) begin
      return (s.r >= running.r) ? s : running;
    end
    distance = root_floor(dist2);
    big_r    = (distance + 64'(running.r) + 64'(s.r)) >> 1;
    k        = big_r >= 64'(running.r) ? big_r - 64'(running.r) : 64'd0;
    for (int i = 0; i < 3; i++) begin
      nc[i] = c0[i];
      if (distance != 0) begin
        off   = (128'(md[i]) * 128'(k)) / 128'(distance);
        nc[i] = d[i] < 0 ? CoordW'(c0[i] - off[31:0]) : CoordW'(c0[i] + off[31:0]);
      end
    end
    n.x = nc[0]; n.y = nc[1]; n.z = nc[2];
    n.r = big_r > 64'(RadMax) ? RadMax : big_r[30:0];
    return n;
  endfunction

  function automatic sphere_t mk(input int x, input int y, input int z, input logic [30:0] r);
    sphere_t s;
    s.x = x; s.y = y; s.z = z; s.r = r;
    return s;
  endfunction

  function automatic sphere_t rand_sphere(input int unsigned spread);
    sphere_t s;
    case ($urandom_range(0, 3))
      0: begin
        s = mk($urandom, $urandom, $urandom, 31'($urandom));
      end
      default: begin
        s.x = $signed($urandom_range(0, spread)) - $signed(spread / 2);
        s.y = $signed($urandom_range(0, spread)) - $signed(spread / 2);
        s.z = $signed($urandom_range(0, spread)) - $signed(spread / 2);
        s.r = 31'($urandom_range(0, spread / 2));
      end
    endcase
    return s;
  endfunction

  task automatic add_row(input sphere_t s, input logic first, input logic known,
                         input sphere_t want);
    row_t r;
    r.s = s; r.first = first; r.known = known; r.want = want;
    rows[row_count] = r;
    row_count++;
  endtask

  function automatic int unsigned gap_len(input int unsigned long_max);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, long_max) :
           ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
  endfunction

  initial begin
    sphere_t z;
    sphere_t want;
    sphere_t s;
    int unsigned n;
    knobs.in_gap_max    = 200;
    knobs.out_stall_max = 300;
    z = mk(0, 0, 0, 31'd0);
    running = z;
    in_ch.valid        = 1'b0;
    in_ch.center_x     = '0;
    in_ch.center_y     = '0;
    in_ch.center_z     = '0;
    in_ch.radius_in    = '0;
    in_ch.first_of_set = 1'b0;

    // Directed part: a merge straight out of reset, extremes, containment cases.
    add_row(mk(0, 0, 0, 31'd0), 1'b0, 1'b1, z);
    add_row(mk(0, 0, 0, 31'h10000), 1'b0, 1'b1, mk(0, 0, 0, 31'h10000));
    add_row(mk(0, 0, 0, 31'h10000), 1'b0, 1'b1, mk(0, 0, 0, 31'h10000));
    add_row(mk(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, RadMax), 1'b1, 1'b1,
            mk(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, RadMax));
    add_row(mk(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, RadMax), 1'b0, 1'b0, z);
    add_row(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 31'd0), 1'b1, 1'b1,
            mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 31'd0));
    add_row(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'd0), 1'b0, 1'b0, z);
    add_row(mk(0, 0, 0, 31'h40000), 1'b1, 1'b1, mk(0, 0, 0, 31'h40000));
    add_row(mk(32'h10000, 0, 0, 31'h10000), 1'b0, 1'b1, mk(0, 0, 0, 31'h40000));
    add_row(mk(32'h300000, 0, 0, 31'h10000), 1'b0, 1'b0, z);
    add_row(mk(-32'sh50000, 32'h70000, -32'sh20000, 31'h8000), 1'b0, 1'b0, z);
    add_row(mk(0, 0, 0, 31'd0), 1'b0, 1'b0, z);
    add_row(mk(0, 0, 0, 31'h7FFF0000), 1'b0, 1'b0, z);
    add_row(mk(32'h1, 32'h1, 32'h1, 31'd1), 1'b1, 1'b1, mk(32'h1, 32'h1, 32'h1, 31'd1));
    add_row(mk(32'h2, 32'h1, 32'h1, 31'd1), 1'b0, 1'b0, z);

    for (int i = 0; i < NumRandom; i++) begin
      s = rand_sphere((i % 4 == 0) ? 32'hFFFFFFF : 32'h3FFFFF);
      add_row(s, ($urandom_range(0, 11) == 0), 1'b0, z);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < row_count; i++) begin
      n = gap_len(knobs.in_gap_max);
      if (n != 0) begin
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
      in_ch.valid        <= 1'b1;
      in_ch.center_x     <= rows[i].s.x;
      in_ch.center_y     <= rows[i].s.y;
      in_ch.center_z     <= rows[i].s.z;
      in_ch.radius_in    <= rows[i].s.r;
      in_ch.first_of_set <= rows[i].first;
      do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
      want    = merge_sphere(rows[i].s, rows[i].first);
      running = want;
      exp_list[exp_wr] = rows[i].known ? rows[i].want : want;
      exp_wr++;
    end
    in_ch.valid <= 1'b0;
    feeding_done = 1'b1;
  end

  // Output side: random back pressure and field-by-field comparison.
  initial begin
    sphere_t want;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, knobs.out_stall_max)) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (exp_rd == exp_wr) begin
          $error("result transfer with no expectation waiting");
          errors++;
        end else begin
          want = exp_list[exp_rd];
          exp_rd++;
          if (out_ch.merged_x !== want.x) begin
            $error("merged_x: expected %0d, got %0d", want.x, out_ch.merged_x); errors++;
          end
          if (out_ch.merged_y !== want.y) begin
            $error("merged_y: expected %0d, got %0d", want.y, out_ch.merged_y); errors++;
          end
          if (out_ch.merged_z !== want.z) begin
            $error("merged_z: expected %0d, got %0d", want.z, out_ch.merged_z); errors++;
          end
          if (out_ch.merged_radius !== want.r) begin
            $error("merged_radius: expected %0d, got %0d", want.r, out_ch.merged_radius);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (feeding_done);
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && exp_rd == exp_wr) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
design/bsm_pkg.sv
design/bsm_in_if.sv
design/bsm_out_if.sv
design/bounding_sphere_merge.sv
test/bsm_tb_if.sv
test/bounding_sphere_merge_tb.sv
